>>> rtl/roit_pkg.sv
// Shared types, codes and defaults for the record offset index table.
package roit_pkg;

  // Default number of table entries.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;

  // Widths of the request and response fields.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned REC_W    = 16;
  localparam int unsigned OFF_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // Record numbers are compared against counts that can reach 65536.
  localparam int unsigned REC_EXT_W = REC_W + 1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 2'd2;

  // Marks an entry that was skipped over by a gap fill.
  localparam logic [OFF_W-1:0] EMPTY_MARK = '1;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INSERT,
    S_LK_DATA,
    S_RV_LAST,
    S_RV_CHECK,
    S_RV_PROBE,
    S_RESULT
  } state_t;

  // One finished response.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [REC_W-1:0]    record;
  } result_t;

endpackage

>>> rtl/roit_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module roit_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/roit_ctrl.sv
// Command sequencer: insert with gap fill, lookup and binary reverse search.
module roit_ctrl #(
  parameter int unsigned TABLE_DEPTH = roit_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request side.
  input  logic                           req_valid,
  output logic                           idle,
  input  logic [roit_pkg::CMD_W-1:0]     command,
  input  logic [roit_pkg::REC_W-1:0]     record_id,
  input  logic [roit_pkg::OFF_W-1:0]     offset_in,
  // Finished response and its hand-off to the output register.
  output logic                           res_ready,
  output roit_pkg::result_t              res,
  input  logic                           res_take,
  // Table memory.
  output logic                           wr_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  output logic [roit_pkg::OFF_W-1:0]     wr_data,
  output logic                           rd_en,
  output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  input  logic [roit_pkg::OFF_W-1:0]     rd_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned XW = roit_pkg::REC_EXT_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(TABLE_DEPTH);

  roit_pkg::state_t state, state_next;

  logic [roit_pkg::CMD_W-1:0] cmd;
  logic [roit_pkg::REC_W-1:0] rec;
  logic [roit_pkg::OFF_W-1:0] key;
  logic [CW-1:0]              fill_count;
  logic [CW-1:0]              lo;
  logic [CW-1:0]              hi;
  logic [AW-1:0]              mid;

  logic [XW-1:0] rec_x;
  logic [XW-1:0] fill_x;
  logic          rec_beyond;
  logic          rec_below_fill;
  logic          fill_below_rec;
  logic          fill_empty;
  logic          key_lt;
  logic          key_gt;
  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_next;
  logic [CW:0]   span_sum;
  logic [AW-1:0] mid_next;
  logic          span_open;

  assign rec_x          = XW'(rec);
  assign fill_x         = XW'(fill_count);
  assign rec_beyond     = rec_x >= DEPTH_X;
  assign rec_below_fill = rec_x < fill_x;
  assign fill_below_rec = fill_x < rec_x;
  assign fill_empty     = fill_count == '0;
  assign key_lt         = key < rd_data;
  assign key_gt         = key > rd_data;

  // Search interval after this step: the first probe opens [0, fill_count),
  // later steps narrow it around the entry that just came back.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (state == roit_pkg::S_RV_CHECK) begin
      lo_next = '0;
      hi_next = fill_count;
    end else if (key_gt) begin
      lo_next = CW'(mid) + CW'(1);
    end else if (key_lt) begin
      hi_next = CW'(mid);
    end
  end

  assign span_sum  = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next  = AW'(span_sum >> 1);
  assign span_open = lo_next < hi_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      roit_pkg::S_IDLE: begin
        if (req_valid) state_next = roit_pkg::S_DECODE;
      end
      roit_pkg::S_DECODE: begin
        unique case (cmd)
          roit_pkg::CMD_INSERT:
            state_next = rec_beyond ? roit_pkg::S_RESULT : roit_pkg::S_INSERT;
          roit_pkg::CMD_LOOKUP:
            state_next = rec_below_fill ? roit_pkg::S_LK_DATA : roit_pkg::S_RESULT;
          roit_pkg::CMD_REVERSE:
            state_next = fill_empty ? roit_pkg::S_RESULT : roit_pkg::S_RV_LAST;
          default:
            state_next = roit_pkg::S_RESULT;
        endcase
      end
      roit_pkg::S_INSERT: begin
        if (!fill_below_rec) state_next = roit_pkg::S_RESULT;
      end
      roit_pkg::S_LK_DATA: begin
        state_next = roit_pkg::S_RESULT;
      end
      roit_pkg::S_RV_LAST: begin
        state_next = key_lt ? roit_pkg::S_RESULT : roit_pkg::S_RV_CHECK;
      end
      roit_pkg::S_RV_CHECK: begin
        state_next = key_gt ? roit_pkg::S_RESULT : roit_pkg::S_RV_PROBE;
      end
      roit_pkg::S_RV_PROBE: begin
        if (!key_lt && !key_gt || !span_open) state_next = roit_pkg::S_RESULT;
      end
      roit_pkg::S_RESULT: begin
        if (res_take) state_next = roit_pkg::S_IDLE;
      end
      default: state_next = roit_pkg::S_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(rec);
    wr_data = key;
    rd_en   = 1'b0;
    rd_addr = AW'(rec);
    unique case (state)
      roit_pkg::S_DECODE: begin
        if (cmd == roit_pkg::CMD_LOOKUP && rec_below_fill) begin
          rd_en = 1'b1;
        end else if (cmd == roit_pkg::CMD_REVERSE && !fill_empty) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      roit_pkg::S_INSERT: begin
        wr_en = 1'b1;
        if (fill_below_rec) begin
          wr_addr = AW'(fill_count);
          wr_data = roit_pkg::EMPTY_MARK;
        end
      end
      roit_pkg::S_RV_LAST: begin
        rd_en   = !key_lt;
        rd_addr = AW'(fill_count - CW'(1));
      end
      roit_pkg::S_RV_CHECK: begin
        rd_en   = !key_gt;
        rd_addr = mid_next;
      end
      roit_pkg::S_RV_PROBE: begin
        rd_en   = (key_lt || key_gt) && span_open;
        rd_addr = mid_next;
      end
      default: ;
    endcase
  end

  assign idle      = state == roit_pkg::S_IDLE;
  assign res_ready = state == roit_pkg::S_RESULT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= roit_pkg::S_IDLE;
      fill_count <= '0;
    end else begin
      state <= state_next;
      if (state == roit_pkg::S_INSERT && (fill_below_rec || rec_x == fill_x)) begin
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  // Request capture, search interval and response payload.
  always_ff @(posedge clk) begin
    unique case (state)
      roit_pkg::S_IDLE: begin
        cmd <= command;
        rec <= record_id;
        key <= offset_in;
      end
      roit_pkg::S_DECODE: begin
        res.record <= '0;
        if (cmd == roit_pkg::CMD_INSERT) begin
          res.status <= rec_beyond ? roit_pkg::ST_NO_ROOM : roit_pkg::ST_OK;
          res.offset <= '0;
        end else if (cmd == roit_pkg::CMD_LOOKUP && !rec_below_fill) begin
          res.status <= roit_pkg::ST_NOT_FOUND;
          res.offset <= roit_pkg::EMPTY_MARK;
        end else begin
          res.status <= roit_pkg::ST_NOT_FOUND;
          res.offset <= '0;
        end
      end
      roit_pkg::S_LK_DATA: begin
        res.status <= roit_pkg::ST_OK;
        res.offset <= rd_data;
      end
      roit_pkg::S_RV_CHECK, roit_pkg::S_RV_PROBE: begin
        lo  <= lo_next;
        hi  <= hi_next;
        mid <= mid_next;
        if (state == roit_pkg::S_RV_PROBE && !key_lt && !key_gt) begin
          res.status <= roit_pkg::ST_OK;
          res.record <= roit_pkg::REC_W'(mid);
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  a_fill_steps: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill_count == $past(fill_count) ||
              fill_count == $past(fill_count) + CW'(1)))
    else $error("fill count moved by more than one");

  a_write_in_fill: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> CW'(wr_addr) <= fill_count)
    else $error("write above the filled part of the table");

  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    state == roit_pkg::S_RV_PROBE |-> lo <= hi && CW'(mid) < hi && CW'(mid) >= lo)
    else $error("search interval out of order");
`endif

endmodule

>>> rtl/record_offset_index_table_unit.sv
// Top level of the record offset index table: controller, table memory and output register.
//
// Usage:
//   Requests enter on req_valid/req_stall with fields command, record_id and
//   offset_in; a request is taken at a rising edge where req_valid is high and
//   req_stall is low. Each request yields exactly one response on
//   rsp_valid/rsp_stall carrying status, offset_out and record_out.
//   Commands: insert writes an offset at a record number, filling any gap
//   above the current fill count with empty marks (all ones); lookup reads an
//   entry; reverse lookup binary-searches the filled entries for an offset.
//   One request at a time: the controller returns to idle as the previous
//   response enters the output register, and takes the next request from idle.
//   An insert writes the gap entries in turn before its own entry; a reverse
//   lookup probes at most about log2(TABLE_DEPTH) + 1 entries through the
//   table's single read port. Refused inserts, lookup misses and empty-table
//   searches go from decode to the result, a key below the first entry after one read.
//   Reset clears the fill count and the control state; the table contents
//   need no clearing because only filled entries are ever read.
//   When the receiver stalls, the response holds in the output register and
//   the block finishes at most one further request before it waits.
module record_offset_index_table_unit #(
  parameter int unsigned TABLE_DEPTH = roit_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [roit_pkg::CMD_W-1:0]    command,
  input  logic [roit_pkg::REC_W-1:0]    record_id,
  input  logic [roit_pkg::OFF_W-1:0]    offset_in,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [roit_pkg::STATUS_W-1:0] status,
  output logic [roit_pkg::OFF_W-1:0]    offset_out,
  output logic [roit_pkg::REC_W-1:0]    record_out
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic              idle;
  logic              res_ready;
  logic              res_take;
  roit_pkg::result_t res;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [roit_pkg::OFF_W-1:0] wr_data;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [roit_pkg::OFF_W-1:0] rd_data;

  // The controller only listens for a new request while it is idle.
  assign req_stall = !idle;

  roit_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .idle      (idle),
    .command   (command),
    .record_id (record_id),
    .offset_in (offset_in),
    .res_ready (res_ready),
    .res       (res),
    .res_take  (res_take),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  roit_ram #(
    .WIDTH(roit_pkg::OFF_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The output register is free when it is empty or its response leaves now.
  assign res_take = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= res_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_ready) begin
      status     <= res.status;
      offset_out <= res.offset;
      record_out <= res.record;
    end
  end

endmodule
